### hdl/assert_macros.svh
// Assertion macros shared by the page allocator RTL.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pcpa_pkg.sv
// Shared types, codes and constants of the per-CPU page allocator.
// Used by every module of the block; depends on nothing.
package pcpa_pkg;

    localparam int ADDR_W      = 34;             // byte address width
    localparam int BASE_W      = ADDR_W + 1;     // rounded-up base may reach 2**34
    localparam int CPU_IN_W    = 3;              // requesting_cpu field width
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;             // cpu + address, padded to bytes
    localparam int OUT_TDATA_W = 40;             // address, padded to bytes
    localparam int CFG_IDX_W   = 2;

    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);

    localparam int NUM_CPUS_DEF  = 8;
    localparam int MAX_PAGES_DEF = 4096;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [ADDR_W-1:0] REGION_START_RST = 34'h0_8000_0000;
    localparam logic [ADDR_W-1:0] REGION_END_RST   = 34'h0_8800_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 2'd1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_BAD_FREE = 2'd2
    } status_t;

    // Class of a queued command, decided by the front end
    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_BAD   = 2'd2
    } kind_t;

    // Fold a CPU index into 0..n-1 by repeated subtraction
    function automatic logic [CPU_IN_W-1:0] cpu_wrap(input logic [CPU_IN_W-1:0] cpu,
                                                     input int unsigned n);
        logic [CPU_IN_W-1:0] c;
        c = cpu;
        for (int i = 0; i < (1 << CPU_IN_W) - 1; i++) begin
            if (32'(c) >= n) begin
                c = c - CPU_IN_W'(n);
            end
        end
        return c;
    endfunction

endpackage

### hdl/pcpa_front.sv
// Front end: accepts commands, folds the CPU index and checks free addresses.
// Pushes classified commands into the command queue; uses pcpa_pkg.
module pcpa_front #(
    parameter int NUM_CPUS  = pcpa_pkg::NUM_CPUS_DEF,
    parameter int MAX_PAGES = pcpa_pkg::MAX_PAGES_DEF
) (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            cmd,
    input  logic [pcpa_pkg::CPU_IN_W-1:0]   requesting_cpu,
    input  logic [pcpa_pkg::ADDR_W-1:0]     page_address,
    input  logic [pcpa_pkg::ADDR_W-1:0]     region_start,
    input  logic [pcpa_pkg::ADDR_W-1:0]     region_end,
    input  logic [pcpa_pkg::BASE_W-1:0]     region_base,
    input  logic [pcpa_pkg::BASE_W-1:0]     region_limit,
    input  logic                            q_full,
    output logic                            q_push,
    output logic [((MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1)
                  + ((NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1) + 1:0] q_din
);

    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int SLOT_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    logic [CPU_W-1:0]              cpu;
    logic [pcpa_pkg::BASE_W-1:0]   pa_ext;
    logic [pcpa_pkg::BASE_W-1:0]   offset;
    logic                          bad;
    logic [SLOT_W-1:0]             slot;
    pcpa_pkg::kind_t               kind;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        cpu    = CPU_W'(pcpa_pkg::cpu_wrap(requesting_cpu, NUM_CPUS));
        pa_ext = {1'b0, page_address};
        offset = pa_ext - region_base;
        // region_limit is the base plus MAX_PAGES pages
        bad    = (|page_address[pcpa_pkg::PAGE_SHIFT-1:0])
              || (page_address < region_start)
              || (page_address >= region_end)
              || (pa_ext < region_base)
              || (pa_ext >= region_limit);
        slot   = offset[pcpa_pkg::PAGE_SHIFT +: SLOT_W];
        if (cmd == pcpa_pkg::CMD_FREE) begin
            kind = bad ? pcpa_pkg::KIND_BAD : pcpa_pkg::KIND_FREE;
        end else begin
            kind = pcpa_pkg::KIND_ALLOC;
        end
        q_din = {slot, cpu, kind};
    end

endmodule

### hdl/pcpa_queue.sv
// Command queue between the front end and the list engine.
// Small register FIFO of depth pcpa_pkg::QUEUE_DEPTH; uses assert_macros.svh.
`include "assert_macros.svh"

module pcpa_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    localparam int DEPTH = pcpa_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    `ASSERT_IMPLIES(a_no_push_full, push, !full, "queue pushed while full")
    `ASSERT_IMPLIES(a_no_pop_empty, pop, !empty, "queue popped while empty")
    `ASSERT_NEXT(a_push_fills, push && !pop, !empty, "queue empty after a push")

endmodule

### hdl/pcpa_back.sv
// List engine: pops classified commands and walks the per-CPU free lists.
// Holds list heads, the link memory and the result register; uses pcpa_pkg.
`include "assert_macros.svh"

module pcpa_back #(
    parameter int NUM_CPUS  = pcpa_pkg::NUM_CPUS_DEF,
    parameter int MAX_PAGES = pcpa_pkg::MAX_PAGES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_empty,
    input  logic [((MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1)
                  + ((NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1) + 1:0] q_dout,
    output logic                             q_pop,
    input  logic [pcpa_pkg::BASE_W-1:0]      region_base,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [pcpa_pkg::ADDR_W-1:0]      m_addr,
    output pcpa_pkg::status_t                m_status
);

    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int SLOT_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_HEAD = 3'b010,
        ST_LINK = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    logic [NUM_CPUS-1:0]           valid_reg, valid_next;
    logic [CPU_W-1:0]              tgt_reg, tgt_next;
    logic                          free_reg, free_next;
    logic [SLOT_W-1:0]             slot_reg, slot_next;
    logic [pcpa_pkg::ADDR_W-1:0]   grant_reg, grant_next;
    logic                          m_valid_reg, m_valid_next;
    logic [pcpa_pkg::ADDR_W-1:0]   m_addr_reg;
    pcpa_pkg::status_t             m_status_reg;

    logic [SLOT_W-1:0]             head_mem [NUM_CPUS];
    logic [SLOT_W-1:0]             head_rd_reg;
    logic [SLOT_W:0]               link_mem [MAX_PAGES];
    logic [SLOT_W:0]               link_rd_reg;

    pcpa_pkg::kind_t               it_kind;
    logic [CPU_W-1:0]              it_cpu;
    logic [SLOT_W-1:0]             it_slot;
    logic                          out_free;

    logic [2*NUM_CPUS-1:0]         rot_dbl;
    logic [NUM_CPUS-1:0]           rot;
    logic [CPU_W-1:0]              pick_k;
    logic [CPU_W:0]                pick_sum;
    logic [CPU_W-1:0]              pick_cpu;

    logic                          head_re, head_we, link_re, link_we;
    logic [CPU_W-1:0]              head_ra;
    logic [SLOT_W-1:0]             head_wd;
    logic [SLOT_W:0]               link_wd;
    logic [pcpa_pkg::BASE_W-1:0]   grant_sum;
    logic                          res_load;
    logic [pcpa_pkg::ADDR_W-1:0]   res_addr;
    pcpa_pkg::status_t             res_status;

    assign m_valid  = m_valid_reg;
    assign m_addr   = m_addr_reg;
    assign m_status = m_status_reg;

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        it_kind  = pcpa_pkg::kind_t'(q_dout[1:0]);
        it_cpu   = q_dout[2 +: CPU_W];
        it_slot  = q_dout[2 + CPU_W +: SLOT_W];
    end

    // First nonempty list at or after the requesting CPU, wrapping around
    always_comb begin
        rot_dbl = {valid_reg, valid_reg} >> it_cpu;
        rot     = rot_dbl[NUM_CPUS-1:0];
        pick_k  = '0;
        for (int i = NUM_CPUS - 1; i >= 0; i--) begin
            if (rot[i]) begin
                pick_k = CPU_W'(i);
            end
        end
        pick_sum = (CPU_W + 1)'(it_cpu) + (CPU_W + 1)'(pick_k);
        if (pick_sum >= (CPU_W + 1)'(NUM_CPUS)) begin
            pick_sum = pick_sum - (CPU_W + 1)'(NUM_CPUS);
        end
        pick_cpu = pick_sum[CPU_W-1:0];
    end

    assign grant_sum = region_base
                     + (pcpa_pkg::BASE_W'(head_rd_reg) << pcpa_pkg::PAGE_SHIFT);

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        tgt_next   = tgt_reg;
        free_next  = free_reg;
        slot_next  = slot_reg;
        grant_next = grant_reg;
        q_pop      = 1'b0;
        head_re    = 1'b0;
        head_ra    = pick_cpu;
        head_we    = 1'b0;
        head_wd    = slot_reg;
        link_re    = 1'b0;
        link_we    = 1'b0;
        link_wd    = {valid_reg[tgt_reg], head_rd_reg};
        res_load   = 1'b0;
        res_addr   = '0;
        res_status = pcpa_pkg::STATUS_OK;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    unique case (it_kind)
                        pcpa_pkg::KIND_BAD: begin
                            if (out_free) begin
                                q_pop      = 1'b1;
                                res_load   = 1'b1;
                                res_status = pcpa_pkg::STATUS_BAD_FREE;
                            end
                        end
                        pcpa_pkg::KIND_FREE: begin
                            q_pop      = 1'b1;
                            tgt_next   = it_cpu;
                            free_next  = 1'b1;
                            slot_next  = it_slot;
                            head_re    = 1'b1;
                            head_ra    = it_cpu;
                            state_next = ST_HEAD;
                        end
                        pcpa_pkg::KIND_ALLOC: begin
                            if (!(|valid_reg)) begin
                                if (out_free) begin
                                    q_pop      = 1'b1;
                                    res_load   = 1'b1;
                                    res_status = pcpa_pkg::STATUS_EMPTY;
                                end
                            end else begin
                                q_pop      = 1'b1;
                                tgt_next   = pick_cpu;
                                free_next  = 1'b0;
                                head_re    = 1'b1;
                                state_next = ST_HEAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_HEAD: begin
                if (free_reg) begin
                    // push: link the old top under the freed page
                    if (out_free) begin
                        link_we             = 1'b1;
                        head_we             = 1'b1;
                        valid_next[tgt_reg] = 1'b1;
                        res_load            = 1'b1;
                        state_next          = ST_IDLE;
                    end
                end else begin
                    link_re    = 1'b1;
                    grant_next = grant_sum[pcpa_pkg::ADDR_W-1:0];
                    state_next = ST_LINK;
                end
            end
            ST_LINK: begin
                // pop: the link of the granted page becomes the new top
                if (out_free) begin
                    head_we             = 1'b1;
                    head_wd             = link_rd_reg[SLOT_W-1:0];
                    valid_next[tgt_reg] = link_rd_reg[SLOT_W];
                    res_load            = 1'b1;
                    res_addr            = grant_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tgt_reg   <= tgt_next;
        free_reg  <= free_next;
        slot_reg  <= slot_next;
        grant_reg <= grant_next;
        if (res_load) begin
            m_addr_reg   <= res_addr;
            m_status_reg <= res_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[tgt_reg] <= head_wd;
        end
        if (head_re) begin
            head_rd_reg <= head_mem[head_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[slot_reg] <= link_wd;
        end
        if (link_re) begin
            link_rd_reg <= link_mem[head_rd_reg];
        end
    end

    `ASSERT_IMPLIES(a_pop_list_live, state_reg == ST_LINK, valid_reg[tgt_reg],
        "popping from an empty list")
    `ASSERT_NEXT(a_push_marks_head, state_reg == ST_HEAD && free_reg && out_free,
        valid_reg[$past(tgt_reg)], "list empty after a push")
    `ASSERT_IMPLIES(a_grant_aligned, m_valid_reg && m_status_reg == pcpa_pkg::STATUS_OK,
        m_addr_reg[pcpa_pkg::PAGE_SHIFT-1:0] == '0, "granted address not page aligned")

endmodule

### hdl/per_cpu_page_free_list_allocator.sv
// Per-CPU page free-list allocator: one LIFO free list per CPU with stealing.
//
// Command channel (s_): s_tuser is the command (0 allocate, 1 free), s_tdata
// carries the requesting CPU and the page address. Result channel (m_):
// m_tdata is the granted address, m_tuser the status (0 ok, 1 no page free,
// 2 bad free). Every command gives exactly one result, in order.
// Configuration channel (cfg_): index 0 writes region_start, index 1
// region_end; it is always ready. Write it only while no command is in flight (not enforced).
// A bad free, or an allocate with every list empty, is answered straight from
// the idle state; a good free takes a head read and then writes the link and
// the head; a granted allocate takes a head read and then a link memory read.
// The list engine runs one command at a time, so it takes no new command
// from the queue before the last one has loaded its result.
// A two-entry command queue lets the front take commands while the engine is
// busy; when the result register is held by m_tready low, the engine waits,
// the queue fills and s_tready drops.
// Reset: all lists empty, region registers back to defaults; the link memory
// needs no clearing pass, as a link is only read after its page was freed.
// Files: pcpa_pkg, pcpa_front, pcpa_queue, pcpa_back.
module per_cpu_page_free_list_allocator #(
    parameter int NUM_CPUS  = pcpa_pkg::NUM_CPUS_DEF,
    parameter int MAX_PAGES = pcpa_pkg::MAX_PAGES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [2:0] requesting_cpu, [36:3] page_address, [39:37] zero
    input  logic [pcpa_pkg::IN_TDATA_W-1:0]      s_tdata,
    // [0] cmd
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [33:0] granted_address, [39:34] zero
    output logic [pcpa_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // [1:0] status
    output logic [pcpa_pkg::STATUS_W-1:0]        m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pcpa_pkg::ADDR_W-1:0]          cfg_data
);

    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int SLOT_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int ITEM_W = SLOT_W + CPU_W + 2;

    localparam logic [pcpa_pkg::BASE_W-1:0] PAGE_LOW =
        pcpa_pkg::BASE_W'(pcpa_pkg::PAGE_BYTES - 1);
    localparam logic [pcpa_pkg::BASE_W-1:0] MAX_BYTES =
        pcpa_pkg::BASE_W'(longint'(MAX_PAGES) * longint'(pcpa_pkg::PAGE_BYTES));
    localparam logic [pcpa_pkg::BASE_W-1:0] BASE_RST =
        ({1'b0, pcpa_pkg::REGION_START_RST} + PAGE_LOW) & ~PAGE_LOW;
    localparam logic [pcpa_pkg::BASE_W-1:0] LIMIT_RST = BASE_RST + MAX_BYTES;

    logic [pcpa_pkg::ADDR_W-1:0] start_reg;
    logic [pcpa_pkg::ADDR_W-1:0] end_reg;
    logic [pcpa_pkg::BASE_W-1:0] base_reg;
    logic [pcpa_pkg::BASE_W-1:0] limit_reg;
    logic [pcpa_pkg::BASE_W-1:0] cfg_ext;
    logic [pcpa_pkg::BASE_W-1:0] base_wr;
    logic [pcpa_pkg::BASE_W-1:0] limit_wr;

    logic                        q_push, q_pop, q_full, q_empty;
    logic [ITEM_W-1:0]           q_din, q_dout;
    logic [pcpa_pkg::ADDR_W-1:0] res_addr;
    pcpa_pkg::status_t           res_status;

    assign cfg_ready = 1'b1;

    // Round the start up to a page; limit is the first address past MAX_PAGES
    always_comb begin
        cfg_ext  = {1'b0, cfg_data};
        base_wr  = (cfg_ext + PAGE_LOW) & ~PAGE_LOW;
        limit_wr = (cfg_ext + PAGE_LOW + MAX_BYTES) & ~PAGE_LOW;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= pcpa_pkg::REGION_START_RST;
            end_reg   <= pcpa_pkg::REGION_END_RST;
            base_reg  <= BASE_RST;
            limit_reg <= LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                pcpa_pkg::CFG_REGION_START: begin
                    start_reg <= cfg_data;
                    base_reg  <= base_wr;
                    limit_reg <= limit_wr;
                end
                pcpa_pkg::CFG_REGION_END: begin
                    end_reg <= cfg_data;
                end
                default: ;
            endcase
        end
    end

    pcpa_front #(
        .NUM_CPUS  (NUM_CPUS),
        .MAX_PAGES (MAX_PAGES)
    ) u_front (
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .cmd            (s_tuser),
        .requesting_cpu (s_tdata[pcpa_pkg::CPU_IN_W-1:0]),
        .page_address   (s_tdata[pcpa_pkg::CPU_IN_W +: pcpa_pkg::ADDR_W]),
        .region_start   (start_reg),
        .region_end     (end_reg),
        .region_base    (base_reg),
        .region_limit   (limit_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_din          (q_din)
    );

    pcpa_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .pop     (q_pop),
        .dout    (q_dout),
        .full    (q_full),
        .empty   (q_empty)
    );

    pcpa_back #(
        .NUM_CPUS  (NUM_CPUS),
        .MAX_PAGES (MAX_PAGES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_dout      (q_dout),
        .q_pop       (q_pop),
        .region_base (base_reg),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_addr      (res_addr),
        .m_status    (res_status)
    );

    assign m_tdata = pcpa_pkg::OUT_TDATA_W'(res_addr);
    assign m_tuser = res_status;

endmodule
